### src/stok_pkg.sv
package stok_pkg;

   localparam int LINE_BITS_DEFAULT   = 20;
   localparam int COLUMN_BITS_DEFAULT = 16;
   localparam int KIND_BITS           = 5;
   localparam int QUEUE_DEPTH         = 4;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ID      = 5'd0,
      KIND_INT     = 5'd1,
      KIND_FN      = 5'd2,
      KIND_I32     = 5'd3,
      KIND_PLUS    = 5'd4,
      KIND_MINUS   = 5'd5,
      KIND_ARROW   = 5'd6,
      KIND_ASSIGN  = 5'd7,
      KIND_TIMES   = 5'd8,
      KIND_DIVIDE  = 5'd9,
      KIND_LPAREN  = 5'd10,
      KIND_RPAREN  = 5'd11,
      KIND_LBRACE  = 5'd12,
      KIND_RBRACE  = 5'd13,
      KIND_LSQUARE = 5'd14,
      KIND_RSQUARE = 5'd15,
      KIND_DECLARE = 5'd16,
      KIND_EOF     = 5'd17,
      KIND_ERROR   = 5'd18
   } kind_type;

   // push strobes from the scanner into the result queue
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FEED    = 8'h0C;
   localparam logic [7:0] CH_RETURN  = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   localparam logic [23:0] PREFIX_FN  = 24'h00666E;
   localparam logic [23:0] PREFIX_I32 = 24'h693332;

   function automatic logic is_letter(input logic [7:0] c);
      is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_RETURN) ||
                 (c == CH_VTAB) || (c == CH_FEED);
   endfunction

   function automatic kind_type op_kind(input logic [7:0] c);
      unique case (c)
         8'h2B:   op_kind = KIND_PLUS;
         8'h3D:   op_kind = KIND_ASSIGN;
         8'h2A:   op_kind = KIND_TIMES;
         8'h2F:   op_kind = KIND_DIVIDE;
         8'h28:   op_kind = KIND_LPAREN;
         8'h29:   op_kind = KIND_RPAREN;
         8'h7B:   op_kind = KIND_LBRACE;
         8'h7D:   op_kind = KIND_RBRACE;
         8'h5B:   op_kind = KIND_LSQUARE;
         8'h5D:   op_kind = KIND_RSQUARE;
         default: op_kind = KIND_ERROR;
      endcase
   endfunction

endpackage

### src/stok_scan.sv
module stok_scan #(
   parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = stok_pkg::COLUMN_BITS_DEFAULT,
   parameter int ENTRY_BITS  = stok_pkg::KIND_BITS + LINE_BITS + 2 * COLUMN_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            char_code,
   input  logic                  end_of_input,
   output stok_pkg::push_type    push,
   output logic [ENTRY_BITS-1:0] slot0,
   output logic [ENTRY_BITS-1:0] slot1
);
   import stok_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUMBER,
      MODE_MINUS,
      MODE_COLON,
      MODE_DONE,
      MODE_ERROR
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [COLUMN_BITS-1:0] start_ff, start_in;
   logic [2:0]             wlen_ff, wlen_in;
   logic [23:0]            prefix_ff, prefix_in;

   logic [COLUMN_BITS-1:0] col_plus;
   logic [LINE_BITS-1:0]   line_plus;
   kind_type               word_kind;

   mode_type               idle_mode;
   logic [LINE_BITS-1:0]   idle_line;
   logic [COLUMN_BITS-1:0] idle_col;
   logic [COLUMN_BITS-1:0] idle_start;
   logic [2:0]             idle_wlen;
   logic [23:0]            idle_prefix;
   logic                   idle_emit;
   kind_type               idle_kind;

   logic                   a_valid, b_valid, use_idle;
   kind_type               a_kind, b_kind;
   logic [COLUMN_BITS-1:0] a_scol, a_ecol, b_scol, b_ecol;

   assign col_plus  = (col_ff == '1) ? col_ff : col_ff + 1'b1;
   assign line_plus = (line_ff == '1) ? line_ff : line_ff + 1'b1;

   always_comb begin
      priority if (wlen_ff == 3'd2 && prefix_ff == PREFIX_FN) begin
         word_kind = KIND_FN;
      end else if (wlen_ff == 3'd3 && prefix_ff == PREFIX_I32) begin
         word_kind = KIND_I32;
      end else begin
         word_kind = KIND_ID;
      end
   end

   // outcome of a byte seen with no token pending
   always_comb begin
      idle_mode   = MODE_IDLE;
      idle_line   = line_ff;
      idle_col    = col_plus;
      idle_start  = start_ff;
      idle_wlen   = wlen_ff;
      idle_prefix = prefix_ff;
      idle_emit   = 1'b0;
      idle_kind   = op_kind(char_code);
      priority if (char_code == CH_NEWLINE) begin
         idle_line = line_plus;
         idle_col  = '0;
      end else if (is_blank(char_code)) begin
         idle_mode = MODE_IDLE;
      end else if (is_letter(char_code)) begin
         idle_mode   = MODE_WORD;
         idle_start  = col_plus;
         idle_wlen   = 3'd1;
         idle_prefix = {16'h0000, char_code};
      end else if (is_digit(char_code)) begin
         idle_mode  = MODE_NUMBER;
         idle_start = col_plus;
      end else if (char_code == CH_MINUS) begin
         idle_mode  = MODE_MINUS;
         idle_start = col_plus;
      end else if (char_code == CH_COLON) begin
         idle_mode  = MODE_COLON;
         idle_start = col_plus;
      end else begin
         idle_emit = 1'b1;
         if (idle_kind == KIND_ERROR) begin
            idle_mode = MODE_ERROR;
         end
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      start_in  = start_ff;
      wlen_in   = wlen_ff;
      prefix_in = prefix_ff;
      a_valid   = 1'b0;
      a_kind    = KIND_ID;
      a_scol    = start_ff;
      a_ecol    = col_ff;
      b_valid   = 1'b0;
      b_kind    = KIND_EOF;
      b_scol    = col_plus;
      b_ecol    = col_plus;
      use_idle  = 1'b0;
      if (fire) begin
         unique case (mode_ff)
            MODE_ERROR: begin
               mode_in = MODE_ERROR;
            end
            MODE_DONE: begin
               b_valid = end_of_input;
            end
            default: begin
               if (end_of_input) begin
                  // flush the pending token, then eof; a pending colon gives an error instead
                  mode_in = MODE_DONE;
                  b_valid = 1'b1;
                  unique case (mode_ff)
                     MODE_WORD: begin
                        a_valid = 1'b1;
                        a_kind  = word_kind;
                     end
                     MODE_NUMBER: begin
                        a_valid = 1'b1;
                        a_kind  = KIND_INT;
                     end
                     MODE_MINUS: begin
                        a_valid = 1'b1;
                        a_kind  = KIND_MINUS;
                        a_ecol  = start_ff;
                     end
                     MODE_COLON: begin
                        a_valid = 1'b1;
                        a_kind  = KIND_ERROR;
                        a_ecol  = start_ff;
                        b_valid = 1'b0;
                        mode_in = MODE_ERROR;
                     end
                     default: begin
                        a_valid = 1'b0;
                     end
                  endcase
               end else begin
                  unique case (mode_ff)
                     MODE_WORD: begin
                        if (is_letter(char_code) || is_digit(char_code) ||
                            char_code == CH_UNDER) begin
                           col_in = col_plus;
                           if (wlen_ff < 3'd3) begin
                              prefix_in = {prefix_ff[15:0], char_code};
                           end
                           if (wlen_ff < 3'd4) begin
                              wlen_in = wlen_ff + 3'd1;
                           end
                        end else begin
                           a_valid  = 1'b1;
                           a_kind   = word_kind;
                           use_idle = 1'b1;
                        end
                     end
                     MODE_NUMBER: begin
                        if (is_digit(char_code)) begin
                           col_in = col_plus;
                        end else begin
                           a_valid  = 1'b1;
                           a_kind   = KIND_INT;
                           use_idle = 1'b1;
                        end
                     end
                     MODE_MINUS: begin
                        a_valid = 1'b1;
                        if (char_code == CH_GREATER) begin
                           a_kind  = KIND_ARROW;
                           a_ecol  = col_plus;
                           col_in  = col_plus;
                           mode_in = MODE_IDLE;
                        end else begin
                           a_kind   = KIND_MINUS;
                           a_ecol   = start_ff;
                           use_idle = 1'b1;
                        end
                     end
                     MODE_COLON: begin
                        a_valid = 1'b1;
                        if (char_code == CH_EQUAL) begin
                           a_kind  = KIND_DECLARE;
                           a_ecol  = col_plus;
                           col_in  = col_plus;
                           mode_in = MODE_IDLE;
                        end else begin
                           a_kind  = KIND_ERROR;
                           a_ecol  = start_ff;
                           mode_in = MODE_ERROR;
                        end
                     end
                     default: begin
                        use_idle = 1'b1;
                     end
                  endcase
                  if (use_idle) begin
                     mode_in   = idle_mode;
                     line_in   = idle_line;
                     col_in    = idle_col;
                     start_in  = idle_start;
                     wlen_in   = idle_wlen;
                     prefix_in = idle_prefix;
                     b_valid   = idle_emit;
                     b_kind    = idle_kind;
                  end
               end
            end
         endcase
      end
   end

   // compact the two candidates into the first free slots
   always_comb begin
      push.first  = a_valid | b_valid;
      push.second = a_valid & b_valid;
      if (a_valid) begin
         slot0 = {a_kind, line_ff, a_scol, a_ecol, ~b_valid};
      end else begin
         slot0 = {b_kind, line_ff, b_scol, b_ecol, 1'b1};
      end
      slot1 = {b_kind, line_ff, b_scol, b_ecol, 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= LINE_BITS'(1);
         col_ff    <= '0;
         start_ff  <= '0;
         wlen_ff   <= '0;
         prefix_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         start_ff  <= start_in;
         wlen_ff   <= wlen_in;
         prefix_ff <= prefix_in;
      end
   end

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ERROR |-> !push.first)
      else $error("result produced after an error");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter reached zero");

   a_end_answers: assert property (@(posedge clock) disable iff (reset)
      fire && end_of_input && mode_ff != MODE_ERROR |-> push.first)
      else $error("end marker produced no result");

endmodule

### src/stok_queue.sv
module stok_queue #(
   parameter int WIDTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  stok_pkg::push_type push,
   input  logic [WIDTH-1:0]   din0,
   input  logic [WIDTH-1:0]   din1,
   output logic               room,
   output logic               dout_valid,
   input  logic               dout_ready,
   output logic [WIDTH-1:0]   dout
);
   import stok_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0] wr_next;
   logic                pop;

   assign pop        = dout_valid & dout_ready;
   assign dout_valid = (count_ff != '0);
   assign dout       = mem_ff[rd_ptr_ff];
   assign room       = (count_ff <= CNT_BITS'(QUEUE_DEPTH - 2));
   assign wr_next    = PTR_BITS'(wr_ptr_ff + 1'b1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.second) begin
         wr_ptr_in = PTR_BITS'(wr_ptr_ff + 2'd2);
      end else if (push.first) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = pop ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push.first) + CNT_BITS'(push.second)
                  - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= din0;
      end
      if (push.second) begin
         mem_ff[wr_next] <= din1;
      end
   end

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.second |-> push.first)
      else $error("second push without first");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.first |-> room)
      else $error("push into a full queue");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && !push.first |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not follow a transfer");

endmodule

### src/source_tokenizer_core.sv
// A completed token is registered into the result queue, whose head drives rsp_.
// One byte per cycle while rsp_ready is high and each byte yields at most one token; a byte
// that yields two tokens (flush plus operator, or flush plus eof) needs two rsp_ transfers.
// req_ready falls when the four-entry result queue has fewer than two free entries.
// Synchronous active-high reset: line 1, column 0, scanner idle, result queue empty.
module source_tokenizer_core #(
   parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = stok_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_char_code,
   input  logic                      req_end_of_input,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [stok_pkg::KIND_BITS-1:0] rsp_kind,
   output logic [LINE_BITS-1:0]      rsp_line,
   output logic [COLUMN_BITS-1:0]    rsp_start_column,
   output logic [COLUMN_BITS-1:0]    rsp_end_column,
   output logic                      rsp_last
);
   import stok_pkg::*;

   localparam int ENTRY_BITS = KIND_BITS + LINE_BITS + 2 * COLUMN_BITS + 1;

   push_type              push;
   logic [ENTRY_BITS-1:0] slot0, slot1, head;
   logic                  fire;

   assign fire = req_valid & req_ready;

   stok_scan #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .push         (push),
      .slot0        (slot0),
      .slot1        (slot1)
   );

   stok_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .din0       (slot0),
      .din1       (slot1),
      .room       (req_ready),
      .dout_valid (rsp_valid),
      .dout_ready (rsp_ready),
      .dout       (head)
   );

   assign {rsp_kind, rsp_line, rsp_start_column, rsp_end_column, rsp_last} = head;

endmodule
